// File: rtl/maus_pkg.sv
// Package: beat types, start code values and defaults for the MPEG-2 access unit splitter.
`default_nettype none

package maus_pkg;

    localparam int OFFSET_BITS_DEF  = 32;
    localparam int MAX_AU_BYTES_DEF = 3145728;

    localparam logic [7:0] CODE_PICTURE    = 8'h00;
    localparam logic [7:0] CODE_SEQ_HEADER = 8'hb3;
    localparam logic [7:0] CODE_SEQ_END    = 8'hb7;
    localparam logic [7:0] CODE_GROUP      = 8'hb8;

    localparam logic [23:0] START_PREFIX = 24'h000001;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [31:0] unit_index;
        logic [31:0] unit_offset;
        logic [21:0] unit_length;
        logic        ended_by_end_code;
    } unit_beat_t;

    function automatic logic is_relevant(input logic [7:0] code);
        logic hit;
        case (code) inside
            CODE_PICTURE, CODE_SEQ_HEADER, CODE_SEQ_END, CODE_GROUP: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// File: rtl/maus_parser.sv
// Start code detector and access unit tracker: stream state and one result per byte.
`default_nettype none

module maus_parser #(
    parameter int OFFSET_BITS  = maus_pkg::OFFSET_BITS_DEF,
    parameter int MAX_AU_BYTES = maus_pkg::MAX_AU_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire maus_pkg::byte_beat_t  beat,
    output      logic                  found,
    output      maus_pkg::unit_beat_t  unit
);

    localparam int LEN_W = (OFFSET_BITS > 25) ? OFFSET_BITS : 25;
    localparam int OFS_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    logic [23:0]            window_reg, window_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [1:0]             ignore_reg, ignore_next;
    logic                   open_reg, open_next;
    logic                   pic_reg, pic_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [31:0]            count_reg, count_next;

    logic                   hit;
    logic                   relevant;
    logic                   is_end;
    logic                   emit;
    logic [OFFSET_BITS-1:0] code_pos;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] end_ofs;
    logic [OFFSET_BITS-1:0] len;
    logic [LEN_W-1:0]       len_ext;
    logic [LEN_W-1:0]       len_sat;
    logic [OFS_W-1:0]       start_ext;

    always_comb
    begin
        hit      = (ignore_reg == 2'd0) && (pos_reg >= OFFSET_BITS'(3))
                   && (window_reg == maus_pkg::START_PREFIX);
        relevant = maus_pkg::is_relevant(beat.data_byte);
        is_end   = (beat.data_byte == maus_pkg::CODE_SEQ_END);
        emit     = hit && relevant && open_reg && pic_reg;
        code_pos = pos_reg - OFFSET_BITS'(3);
        pos_inc  = pos_reg + OFFSET_BITS'(1);
        end_ofs  = is_end ? pos_inc : code_pos;
        len      = end_ofs - start_reg;
        len_ext  = LEN_W'(len);
        len_sat  = (len_ext > LEN_W'(MAX_AU_BYTES)) ? LEN_W'(MAX_AU_BYTES) : len_ext;
        start_ext = OFS_W'(start_reg);

        found                  = emit;
        unit.unit_index        = count_reg;
        unit.unit_offset       = start_ext[31:0];
        unit.unit_length       = len_sat[21:0];
        unit.ended_by_end_code = is_end;

        window_next = {window_reg[15:0], beat.data_byte};
        pos_next    = pos_inc;
        ignore_next = 2'd0;
        open_next   = open_reg;
        pic_next    = pic_reg;
        start_next  = start_reg;
        count_next  = count_reg;

        if (ignore_reg != 2'd0)
        begin
            ignore_next = ignore_reg - 2'd1;
        end
        else if (hit)
        begin
            ignore_next = 2'd3;
            if (emit)
            begin
                count_next = count_reg + 32'd1;
                if (is_end)
                begin
                    open_next = 1'b0;
                    pic_next  = 1'b0;
                end
                else
                begin
                    start_next = code_pos;
                    pic_next   = (beat.data_byte == maus_pkg::CODE_PICTURE);
                end
            end
            else if (relevant)
            begin
                if (beat.data_byte == maus_pkg::CODE_PICTURE)
                begin
                    pic_next = 1'b1;
                end
                if (!open_reg)
                begin
                    open_next  = 1'b1;
                    start_next = code_pos;
                end
            end
        end

        // drop any open unit and restart at end of stream
        if (beat.last_byte)
        begin
            window_next = '0;
            pos_next    = '0;
            ignore_next = 2'd0;
            open_next   = 1'b0;
            pic_next    = 1'b0;
            start_next  = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            ignore_reg <= 2'd0;
            open_reg   <= 1'b0;
            pic_reg    <= 1'b0;
            start_reg  <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            ignore_reg <= ignore_next;
            open_reg   <= open_next;
            pic_reg    <= pic_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mpeg2_access_unit_splitter_core.sv
// Top level: input register, access unit tracker and result register of the splitter.
//
//   channel  | direction | handshake                | beat type
//   byte_*   | in        | byte_valid / byte_stall  | maus_pkg::byte_beat_t
//   unit_*   | out       | unit_valid / unit_stall  | maus_pkg::unit_beat_t
//
// One byte per cycle unless a held result stalls; each result is registered before it leaves.
// The input register feeds the tracker, whose state updates once per byte.
// Reset clears all stream state; after a beat with last_byte set the state restarts.
// A stalled result holds its register; the input side stalls only when both
// registers are full and the result cannot leave.
`default_nettype none

module mpeg2_access_unit_splitter_core #(
    parameter int OFFSET_BITS  = maus_pkg::OFFSET_BITS_DEF,
    parameter int MAX_AU_BYTES = maus_pkg::MAX_AU_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output      logic                  byte_stall,
    input  wire maus_pkg::byte_beat_t  byte_beat,
    output      logic                  unit_valid,
    input  wire logic                  unit_stall,
    output      maus_pkg::unit_beat_t  unit_beat
);

    logic                  beat_valid_reg, beat_valid_next;
    maus_pkg::byte_beat_t  beat_reg;
    logic                  unit_valid_reg, unit_valid_next;
    maus_pkg::unit_beat_t  unit_reg;

    logic                  proc_en;
    logic                  take;
    logic                  found;
    maus_pkg::unit_beat_t  unit_res;

    assign proc_en    = beat_valid_reg && (!unit_valid_reg || !unit_stall);
    assign byte_stall = beat_valid_reg && !proc_en;
    assign take       = byte_valid && !byte_stall;
    assign unit_valid = unit_valid_reg;
    assign unit_beat  = unit_reg;

    maus_parser #(
        .OFFSET_BITS  (OFFSET_BITS),
        .MAX_AU_BYTES (MAX_AU_BYTES)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc_en),
        .beat  (beat_reg),
        .found (found),
        .unit  (unit_res)
    );

    always_comb
    begin
        beat_valid_next = beat_valid_reg;
        if (take)
        begin
            beat_valid_next = 1'b1;
        end
        else if (proc_en)
        begin
            beat_valid_next = 1'b0;
        end

        unit_valid_next = unit_valid_reg;
        if (proc_en && found)
        begin
            unit_valid_next = 1'b1;
        end
        else if (unit_valid_reg && !unit_stall)
        begin
            unit_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
            unit_valid_reg <= 1'b0;
        end
        else
        begin
            beat_valid_reg <= beat_valid_next;
            unit_valid_reg <= unit_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= byte_beat;
        end
        if (proc_en && found)
        begin
            unit_reg <= unit_res;
        end
    end

    a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> beat_valid_reg)
        else $error("input stalled with no byte held");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && found |=> unit_valid_reg)
        else $error("emitted unit not loaded into result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid_reg && unit_stall |-> !proc_en)
        else $error("stalled result may be overwritten");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid_reg && unit_stall |=> unit_valid_reg && $stable(unit_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// File: sim/mpeg2_access_unit_splitter_core_tb.sv
// Testbench: random and directed byte streams into the access unit splitter, checked by a scoreboard.
module mpeg2_access_unit_splitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int AU_BYTE_LIMIT  = 65536;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PHASE_BYTES    = 365;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic [7:0] CODE_USER_DATA = 8'hb2;

    class unit_scoreboard;
        maus_pkg::unit_beat_t pending_units[$];
        int unsigned mismatches;
        int unsigned length_cap;
        logic [23:0] window;
        logic [31:0] position;
        logic [31:0] start_offset;
        logic [31:0] unit_count;
        logic [1:0]  skip_left;
        bit          unit_is_open;
        bit          picture_seen;

        function new(int unsigned cap);
            length_cap = cap;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            window = '0;
            position = '0;
            start_offset = '0;
            unit_count = '0;
            skip_left = '0;
            unit_is_open = 1'b0;
            picture_seen = 1'b0;
        endfunction

        function void close_unit(logic [31:0] stop_at, bit by_end);
            maus_pkg::unit_beat_t entry;
            logic [31:0] span;
            span = stop_at - start_offset;
            if (span > length_cap)
                span = length_cap;
            entry.unit_index = unit_count;
            entry.unit_offset = start_offset;
            entry.unit_length = span[21:0];
            entry.ended_by_end_code = by_end;
            pending_units = {pending_units, entry};
            unit_count++;
        endfunction

        function void note_byte(maus_pkg::byte_beat_t beat);
            logic [31:0] code_at;
            bit          relevant;
            code_at = position - 32'd3;
            relevant = beat.data_byte == maus_pkg::CODE_PICTURE ||
                       beat.data_byte == maus_pkg::CODE_SEQ_HEADER ||
                       beat.data_byte == maus_pkg::CODE_SEQ_END ||
                       beat.data_byte == maus_pkg::CODE_GROUP;
            if (skip_left != 0)
                skip_left--;
            else if (position >= 32'd3 && window == maus_pkg::START_PREFIX)
            begin
                skip_left = 2'd3;
                if (relevant && unit_is_open && picture_seen)
                begin
                    if (beat.data_byte == maus_pkg::CODE_SEQ_END)
                    begin
                        close_unit(code_at + 32'd4, 1'b1);
                        unit_is_open = 1'b0;
                        picture_seen = 1'b0;
                    end
                    else
                    begin
                        close_unit(code_at, 1'b0);
                        start_offset = code_at;
                        picture_seen = beat.data_byte == maus_pkg::CODE_PICTURE;
                    end
                end
                else if (relevant)
                begin
                    if (beat.data_byte == maus_pkg::CODE_PICTURE)
                        picture_seen = 1'b1;
                    if (!unit_is_open)
                    begin
                        unit_is_open = 1'b1;
                        start_offset = code_at;
                    end
                end
            end
            window = {window[15:0], beat.data_byte};
            position++;
            if (beat.last_byte)
                restart();
        endfunction

        function void check_unit(maus_pkg::unit_beat_t got);
            maus_pkg::unit_beat_t want;
            if (pending_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected unit: idx=%0d off=%0d len=%0d end=%0b",
                             got.unit_index, got.unit_offset, got.unit_length,
                             got.ended_by_end_code);
                return;
            end
            want = pending_units.pop_front();
            if (got.unit_index !== want.unit_index || got.unit_offset !== want.unit_offset ||
                got.unit_length !== want.unit_length ||
                got.ended_by_end_code !== want.ended_by_end_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unit mismatch: expected idx=%0d off=%0d len=%0d end=%0b,",
                              " got idx=%0d off=%0d len=%0d end=%0b"},
                             want.unit_index, want.unit_offset, want.unit_length,
                             want.ended_by_end_code, got.unit_index, got.unit_offset,
                             got.unit_length, got.ended_by_end_code);
            end
        endfunction

        function int pending();
            return pending_units.size();
        endfunction

        function void finish_check();
            if (pending_units.size() != 0)
            begin
                mismatches += pending_units.size();
                $display("%0d expected units never arrived", pending_units.size());
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 byte_valid = 1'b0;
    logic                 byte_stall;
    maus_pkg::byte_beat_t byte_beat = '0;
    logic                 unit_valid;
    logic                 unit_stall = 1'b0;
    maus_pkg::unit_beat_t unit_beat;

    unit_scoreboard sb;
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;

    mpeg2_access_unit_splitter_core #(
        .MAX_AU_BYTES(AU_BYTE_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_beat(byte_beat),
        .unit_valid(unit_valid),
        .unit_stall(unit_stall),
        .unit_beat(unit_beat)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (unit_valid && !unit_stall)
                sb.check_unit(unit_beat);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                unit_stall <= 1'b1;
            end
            else
                unit_stall <= $urandom_range(99) < stall_pct;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        maus_pkg::byte_beat_t beat;
        beat.data_byte = data;
        beat.last_byte = last;
        while ($urandom_range(99) < send_gap_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_beat <= beat;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sb.note_byte(beat);
        bytes_sent++;
    endtask

    task automatic send_code(input logic [7:0] code, input logic last);
        send_byte(maus_pkg::START_PREFIX[23:16], 1'b0);
        send_byte(maus_pkg::START_PREFIX[15:8], 1'b0);
        send_byte(maus_pkg::START_PREFIX[7:0], 1'b0);
        send_byte(code, last);
    endtask

    task automatic send_payload(input int unsigned count);
        repeat (count)
            send_byte(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0);
    endtask

    task automatic wait_for_units();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned target;
        int unsigned stream_end;
        int unsigned pick;
        sb = new(AU_BYTE_LIMIT);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_code(maus_pkg::CODE_SEQ_HEADER, 1'b0);
        send_code(maus_pkg::CODE_PICTURE, 1'b0);
        send_byte(maus_pkg::START_PREFIX[15:8], 1'b0);
        send_byte(maus_pkg::START_PREFIX[7:0], 1'b0);
        send_byte(maus_pkg::CODE_GROUP, 1'b0);
        send_byte(8'hff, 1'b0);
        send_code(CODE_USER_DATA, 1'b0);
        send_code(maus_pkg::CODE_GROUP, 1'b0);
        send_code(maus_pkg::CODE_PICTURE, 1'b0);
        send_code(maus_pkg::CODE_SEQ_END, 1'b0);
        send_code(maus_pkg::CODE_PICTURE, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(maus_pkg::START_PREFIX[15:8], 1'b0);
        send_byte(maus_pkg::START_PREFIX[7:0], 1'b0);
        send_byte(maus_pkg::CODE_SEQ_HEADER, 1'b1);
        wait_for_units();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    send_gap_pct = 34;
                    stall_pct = 34;
                    hold_request = 400;
                end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                stream_end = bytes_sent + $urandom_range(20, 200);
                while (bytes_sent < stream_end)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                    begin
                        if ($urandom_range(3) == 0)
                        begin
                            send_code(maus_pkg::CODE_SEQ_HEADER, 1'b0);
                            send_payload($urandom_range(0, 8));
                        end
                        if ($urandom_range(2) == 0)
                        begin
                            send_code(maus_pkg::CODE_GROUP, 1'b0);
                            send_payload($urandom_range(0, 4));
                        end
                        repeat ($urandom_range(1, 3))
                        begin
                            send_code(maus_pkg::CODE_PICTURE, 1'b0);
                            send_payload($urandom_range(0, 24));
                            if ($urandom_range(4) == 0)
                            begin
                                send_code(8'($urandom_range(1, 175)), 1'b0);
                                send_payload($urandom_range(0, 12));
                            end
                        end
                        if ($urandom_range(4) == 0)
                            send_code(maus_pkg::CODE_SEQ_END, 1'b0);
                    end
                    else if (pick < 88)
                    begin
                        repeat ($urandom_range(4, 16))
                        begin
                            case ($urandom_range(9))
                                0, 1, 2, 3: send_byte(maus_pkg::START_PREFIX[15:8], 1'b0);
                                4: send_byte(maus_pkg::START_PREFIX[7:0], 1'b0);
                                5: send_byte(maus_pkg::CODE_SEQ_HEADER, 1'b0);
                                6: send_byte(maus_pkg::CODE_SEQ_END, 1'b0);
                                7: send_byte(maus_pkg::CODE_GROUP, 1'b0);
                                default: send_byte(8'($urandom_range(255)), 1'b0);
                            endcase
                        end
                    end
                    else
                    begin
                        send_byte(maus_pkg::START_PREFIX[23:16], 1'b0);
                        send_byte(maus_pkg::START_PREFIX[15:8], 1'b0);
                        send_byte(8'($urandom_range(2, 255)), 1'b0);
                    end
                end
                if ($urandom_range(3) == 0)
                    send_code(maus_pkg::CODE_SEQ_END, 1'b1);
                else
                    send_byte(8'($urandom_range(255)), 1'b1);
            end
            wait_for_units();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        sb.finish_check();
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
rtl/maus_pkg.sv
rtl/maus_parser.sv
rtl/mpeg2_access_unit_splitter_core.sv
sim/mpeg2_access_unit_splitter_core_tb.sv
